### rtl/core/gep_pkg.sv
// shared types and constants for the gbm euler path payoff core
package gep_pkg;

    // fixed-point formats
    localparam int FRAC_BITS   = 24;
    localparam int SAMPLE_FRAC = 12;
    localparam int DIGIT_BITS  = 16;

    // 1.0 in q8.24
    localparam logic signed [31:0] ONE_Q = 32'sh0100_0000;

    // result field widths
    localparam int PATH_W     = 32;
    localparam int TOTAL_W    = 48;
    localparam int COUNT_W    = 24;
    localparam int OUT_DATA_W = PATH_W + TOTAL_W + COUNT_W;

    // configuration register widths
    localparam int DRIFT_W  = 32;
    localparam int VOL_W    = 31;
    localparam int SQRT_W   = 25;
    localparam int STRIKE_W = 31;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 32;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_DRIFT_FINE   = 3'd0,
        CFG_DRIFT_COARSE = 3'd1,
        CFG_VOLATILITY   = 3'd2,
        CFG_SQRT_DT      = 3'd3,
        CFG_STRIKE       = 3'd4,
        CFG_COUPLED      = 3'd5
    } t_cfg_idx;

    // control to the shared multiplier
    typedef struct packed {
        logic start;
        logic neg;
        logic frac_hi;
    } t_mul_req;

    // status from the shared multiplier
    typedef struct packed {
        logic done;
        logic sat;
    } t_mul_rsp;

endpackage

### rtl/core/gep_mul.sv
// digit-serial sign-magnitude multiplier with rounding and saturation
module gep_mul #(
    parameter int MAG_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gep_pkg::t_mul_req            i_req,
    input  logic [MAG_BITS-1:0]          i_a,
    input  logic [MAG_BITS-1:0]          i_b,
    output gep_pkg::t_mul_rsp            o_rsp,
    output logic signed [VALUE_BITS-1:0] o_res
);

    localparam int DIG = gep_pkg::DIGIT_BITS;
    localparam int ND  = (MAG_BITS + DIG - 1) / DIG;
    localparam int LW  = ND * DIG;
    localparam int PFW = MAG_BITS + LW;
    localparam int RW  = PFW + 1;
    localparam int SW  = MAG_BITS + DIG;
    localparam int CW  = $clog2(ND + 1);

    localparam logic [RW-1:0] R_ONE  = RW'(1);
    localparam logic [RW-1:0] HALF_H = R_ONE << (gep_pkg::FRAC_BITS - 1);
    localparam logic [RW-1:0] HALF_L = R_ONE << (gep_pkg::SAMPLE_FRAC - 1);
    localparam logic [RW-1:0] LIM_N  = R_ONE << (VALUE_BITS - 1);
    localparam logic [RW-1:0] LIM_P  = LIM_N - R_ONE;
    localparam logic [VALUE_BITS-1:0] V_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] V_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic                  r_run, n_run;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_done, n_done;
    logic [MAG_BITS-1:0]   r_a, n_a;
    logic [LW-1:0]         r_b, n_b;
    logic [MAG_BITS-1:0]   r_acc, n_acc;
    logic [LW-1:0]         r_lo, n_lo;
    logic                  r_neg, n_neg;
    logic                  r_fhi, n_fhi;
    logic                  r_sat, n_sat;
    logic [VALUE_BITS-1:0] r_res, n_res;

    logic [SW-1:0]         step_sum;
    logic [RW-1:0]         rnd;
    logic [RW-1:0]         mag;
    logic                  over;

    // one digit of b per cycle, low half shifts into r_lo
    assign step_sum = (SW'(r_a) * SW'(r_b[DIG-1:0])) + SW'(r_acc);

    // round to nearest, ties away from zero, then clamp to the value range
    assign rnd  = RW'({r_acc, r_lo}) + (r_fhi ? HALF_H : HALF_L);
    assign mag  = r_fhi ? (rnd >> gep_pkg::FRAC_BITS) : (rnd >> gep_pkg::SAMPLE_FRAC);
    assign over = mag > (r_neg ? LIM_N : LIM_P);

    always_comb begin
        n_run  = r_run;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_lo   = r_lo;
        n_neg  = r_neg;
        n_fhi  = r_fhi;
        n_sat  = r_sat;
        n_res  = r_res;
        if (i_req.start) begin
            n_run = 1'b1;
            n_cnt = CW'(ND);
            n_a   = i_a;
            n_b   = LW'(i_b);
            n_acc = '0;
            n_neg = i_req.neg;
            n_fhi = i_req.frac_hi;
        end else if (r_run && (r_cnt != '0)) begin
            n_acc = step_sum[SW-1:DIG];
            n_lo  = {step_sum[DIG-1:0], r_lo[LW-1:DIG]};
            n_b   = r_b >> DIG;
            n_cnt = r_cnt - 1'b1;
        end else if (r_run) begin
            n_run  = 1'b0;
            n_done = 1'b1;
            n_sat  = over;
            if (over) begin
                n_res = r_neg ? V_MIN : V_MAX;
            end else if (r_neg) begin
                n_res = ~mag[VALUE_BITS-1:0] + 1'b1;
            end else begin
                n_res = mag[VALUE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_lo  <= n_lo;
        r_neg <= n_neg;
        r_fhi <= n_fhi;
        r_sat <= n_sat;
        r_res <= n_res;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_res      = $signed(r_res);

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_run)
        else $error("multiplier started while busy");

    a_round_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && (r_cnt == '0) && !i_req.start) |=> (r_done && !r_run))
        else $error("rounding cycle did not finish the product");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");
`endif

endmodule

### rtl/core/gbm_euler_path_payoff_core.sv
// gbm euler-maruyama path engine with call payoff and two-level coupling
// sequence: increment, diffusion and path-update products of ND = ceil(max(VALUE_BITS,31)/16) digits
//   each; coupled mode adds an increment sum, and each coarse step a second diffusion and path update
// a last request adds payoff, difference and total states; result registered, held off by a full output
// throughput: one request at a time, set by the single shared multiplier (three products per fine step)
// reset: synchronous active low; state and config to reset values, paths restart at 1.0, totals cleared
module gbm_euler_path_payoff_core #(
    parameter int REFINE_FACTOR = 2,
    parameter int VALUE_BITS    = 32,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,

    // request stream
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // normal_sample
    input  logic                                    s_axis_tlast,  // last_step
    input  logic                                    s_axis_tuser,  // clear_total

    // result stream
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [gep_pkg::OUT_DATA_W-1:0]          m_axis_tdata,  // path_value, running_total, path_count
    output logic                                    m_axis_tuser,  // saturated

    // configuration writes
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [gep_pkg::CFG_A_W-1:0]             i_cfg_addr,
    input  logic [gep_pkg::CFG_D_W-1:0]             i_cfg_data
);

    // state width must hold 1.0 even for narrow value ranges
    localparam int SW = (VALUE_BITS > 25) ? VALUE_BITS : 26;
    // operand magnitude width of the shared multiplier
    localparam int MW = (SW > 31) ? SW : 31;
    // headroom width for adds before clamping
    localparam int XW = ((SW > 32) ? SW : 32) + 2;
    localparam int PW = $clog2(REFINE_FACTOR);
    localparam int TW = gep_pkg::TOTAL_W + 1;
    localparam int VB = VALUE_BITS;
    localparam int SB = SAMPLE_BITS;

    localparam logic signed [XW-1:0] VMAX_X = XW'((64'sd1 <<< (VB - 1)) - 64'sd1);
    localparam logic signed [XW-1:0] VMIN_X = XW'(-(64'sd1 <<< (VB - 1)));
    localparam logic signed [XW-1:0] OMAX_X = XW'(64'sd2147483647);
    localparam logic signed [XW-1:0] OMIN_X = XW'(-64'sd2147483648);
    localparam logic signed [TW-1:0] TMAX   = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [TW-1:0] TMIN   = 49'sh1_8000_0000_0000;
    localparam logic signed [SW-1:0] ONE_S  = SW'(gep_pkg::ONE_Q);
    localparam logic [gep_pkg::COUNT_W-1:0] CNT_MAX = '1;
    localparam logic [PW-1:0] POS_END = PW'(REFINE_FACTOR - 1);

    // sequencer, one-hot
    typedef enum logic [12:0] {
        S_IDLE    = 13'b0_0000_0000_0001,
        S_DW_ISS  = 13'b0_0000_0000_0010,
        S_DW_WAIT = 13'b0_0000_0000_0100,
        S_VD_ISS  = 13'b0_0000_0000_1000,
        S_VD_WAIT = 13'b0_0000_0001_0000,
        S_G_ADD   = 13'b0_0000_0010_0000,
        S_XG_ISS  = 13'b0_0000_0100_0000,
        S_XG_WAIT = 13'b0_0000_1000_0000,
        S_X_ADD   = 13'b0_0001_0000_0000,
        S_INC     = 13'b0_0010_0000_0000,
        S_PAY     = 13'b0_0100_0000_0000,
        S_DIFF    = 13'b0_1000_0000_0000,
        S_TOT     = 13'b1_0000_0000_0000
    } t_state;

    // configuration registers
    logic signed [gep_pkg::DRIFT_W-1:0] r_drift_f;
    logic signed [gep_pkg::DRIFT_W-1:0] r_drift_c;
    logic [gep_pkg::VOL_W-1:0]          r_vol;
    logic [gep_pkg::SQRT_W-1:0]         r_sqrt;
    logic [gep_pkg::STRIKE_W-1:0]       r_strike;
    logic                               r_coupled;

    // sequencer and path state
    t_state                             r_state, n_state;
    logic [SB-1:0]                      r_smp, n_smp;
    logic                               r_last, n_last;
    logic                               r_step_crs, n_step_crs;
    logic signed [VB-1:0]               r_dw, n_dw;
    logic signed [VB-1:0]               r_g, n_g;
    logic signed [SW-1:0]               r_fine, n_fine;
    logic signed [SW-1:0]               r_crs, n_crs;
    logic signed [VB-1:0]               r_inc, n_inc;
    logic [PW-1:0]                      r_pos, n_pos;
    logic signed [gep_pkg::TOTAL_W-1:0] r_total, n_total;
    logic [gep_pkg::COUNT_W-1:0]        r_count, n_count;
    logic                               r_ovf, n_ovf;
    logic signed [VB-1:0]               r_pf, n_pf;
    logic signed [VB-1:0]               r_pc, n_pc;
    logic signed [gep_pkg::PATH_W-1:0]  r_val, n_val;

    // result holding register
    logic                               r_out_valid, n_out_valid;
    logic [gep_pkg::PATH_W-1:0]         r_out_val, n_out_val;
    logic [gep_pkg::TOTAL_W-1:0]        r_out_total, n_out_total;
    logic [gep_pkg::COUNT_W-1:0]        r_out_count, n_out_count;
    logic                               r_out_sat, n_out_sat;

    // shared multiplier
    gep_pkg::t_mul_req                  mul_req;
    gep_pkg::t_mul_rsp                  mul_rsp;
    logic [MW-1:0]                      mul_a;
    logic [MW-1:0]                      mul_b;
    logic signed [VB-1:0]               mul_res;

    // operand selection
    logic [SB-1:0]                      smp_mag;
    logic signed [VB-1:0]               dw_sel;
    logic [VB-1:0]                      dw_mag;
    logic signed [SW-1:0]               x_sel;
    logic [SW-1:0]                      x_mag;
    logic [VB-1:0]                      g_mag;
    logic signed [gep_pkg::DRIFT_W-1:0] drift_sel;

    logic                               in_fire;
    logic                               out_free;

    // clamp a widened sum into the path value range, flag in the top bit
    function automatic logic [VB:0] sat_v(input logic signed [XW-1:0] s);
        logic [VB:0] r;
        if (s > VMAX_X) begin
            r = {1'b1, VMAX_X[VB-1:0]};
        end else if (s < VMIN_X) begin
            r = {1'b1, VMIN_X[VB-1:0]};
        end else begin
            r = {1'b0, s[VB-1:0]};
        end
        return r;
    endfunction

    // configuration writes are taken at any time; software must keep them to idle periods, the block does not check
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drift_f <= '0;
            r_drift_c <= '0;
            r_vol     <= gep_pkg::VOL_W'(gep_pkg::ONE_Q);
            r_sqrt    <= gep_pkg::SQRT_W'(gep_pkg::ONE_Q);
            r_strike  <= gep_pkg::STRIKE_W'(gep_pkg::ONE_Q);
            r_coupled <= 1'b0;
        end else if (i_cfg_valid) begin
            case (gep_pkg::t_cfg_idx'(i_cfg_addr))
                gep_pkg::CFG_DRIFT_FINE: begin
                    r_drift_f <= $signed(i_cfg_data);
                end
                gep_pkg::CFG_DRIFT_COARSE: begin
                    r_drift_c <= $signed(i_cfg_data);
                end
                gep_pkg::CFG_VOLATILITY: begin
                    r_vol <= i_cfg_data[gep_pkg::VOL_W-1:0];
                end
                gep_pkg::CFG_SQRT_DT: begin
                    r_sqrt <= i_cfg_data[gep_pkg::SQRT_W-1:0];
                end
                gep_pkg::CFG_STRIKE: begin
                    r_strike <= i_cfg_data[gep_pkg::STRIKE_W-1:0];
                end
                gep_pkg::CFG_COUPLED: begin
                    r_coupled <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // new request only between steps; a pending result does not block it
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // magnitudes for the sign-magnitude multiplier
    assign smp_mag   = r_smp[SB-1] ? (~r_smp + 1'b1) : r_smp;
    assign dw_sel    = r_step_crs ? r_inc : r_dw;
    assign dw_mag    = dw_sel[VB-1] ? (~dw_sel + 1'b1) : dw_sel;
    assign x_sel     = r_step_crs ? r_crs : r_fine;
    assign x_mag     = x_sel[SW-1] ? (~x_sel + 1'b1) : x_sel;
    assign g_mag     = r_g[VB-1] ? (~r_g + 1'b1) : r_g;
    assign drift_sel = r_step_crs ? r_drift_c : r_drift_f;

    // multiplier operand mux per issue state
    always_comb begin
        mul_req = '0;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            S_DW_ISS: begin
                // brownian increment: q4.12 sample times sqrt(dt), q8.24 product
                mul_req.start   = 1'b1;
                mul_req.neg     = r_smp[SB-1];
                mul_req.frac_hi = 1'b0;
                mul_a           = MW'(smp_mag);
                mul_b           = MW'(r_sqrt);
            end
            S_VD_ISS: begin
                // diffusion term: volatility times increment
                mul_req.start   = 1'b1;
                mul_req.neg     = dw_sel[VB-1];
                mul_req.frac_hi = 1'b1;
                mul_a           = MW'(r_vol);
                mul_b           = MW'(dw_mag);
            end
            S_XG_ISS: begin
                // path update: x times growth factor
                mul_req.start   = 1'b1;
                mul_req.neg     = x_sel[SW-1] ^ r_g[VB-1];
                mul_req.frac_hi = 1'b1;
                mul_a           = MW'(x_mag);
                mul_b           = MW'(g_mag);
            end
            default: begin
            end
        endcase
    end

    gep_mul #(
        .MAG_BITS   (MW),
        .VALUE_BITS (VB)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_rsp   (mul_rsp),
        .o_res   (mul_res)
    );

    // sequencer and datapath next values
    always_comb begin
        logic [VB:0]              sv;
        logic [VB:0]              sc;
        logic signed [XW-1:0]     xs;
        logic signed [XW-1:0]     xc;
        logic signed [TW-1:0]     ts;

        n_state     = r_state;
        n_smp       = r_smp;
        n_last      = r_last;
        n_step_crs  = r_step_crs;
        n_dw        = r_dw;
        n_g         = r_g;
        n_fine      = r_fine;
        n_crs       = r_crs;
        n_inc       = r_inc;
        n_pos       = r_pos;
        n_total     = r_total;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_pf        = r_pf;
        n_pc        = r_pc;
        n_val       = r_val;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_val   = r_out_val;
        n_out_total = r_out_total;
        n_out_count = r_out_count;
        n_out_sat   = r_out_sat;
        sv          = '0;
        sc          = '0;
        xs          = '0;
        xc          = '0;
        ts          = '0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_smp   = s_axis_tdata[SB-1:0];
                    n_last  = s_axis_tlast;
                    n_state = S_DW_ISS;
                    // clear acts before this request's contribution
                    if (s_axis_tuser) begin
                        n_total = '0;
                        n_count = '0;
                    end
                end
            end
            S_DW_ISS: begin
                n_state = S_DW_WAIT;
            end
            S_DW_WAIT: begin
                if (mul_rsp.done) begin
                    n_dw    = mul_res;
                    n_ovf   = r_ovf | mul_rsp.sat;
                    n_state = S_VD_ISS;
                end
            end
            S_VD_ISS: begin
                n_state = S_VD_WAIT;
            end
            S_VD_WAIT: begin
                if (mul_rsp.done) begin
                    n_ovf   = r_ovf | mul_rsp.sat;
                    n_state = S_G_ADD;
                end
            end
            S_G_ADD: begin
                // growth factor: drift plus diffusion
                xs      = XW'(drift_sel) + XW'(mul_res);
                sv      = sat_v(xs);
                n_g     = $signed(sv[VB-1:0]);
                n_ovf   = r_ovf | sv[VB];
                n_state = S_XG_ISS;
            end
            S_XG_ISS: begin
                n_state = S_XG_WAIT;
            end
            S_XG_WAIT: begin
                if (mul_rsp.done) begin
                    n_ovf   = r_ovf | mul_rsp.sat;
                    n_state = S_X_ADD;
                end
            end
            S_X_ADD: begin
                xs    = XW'(x_sel) + XW'(mul_res);
                sv    = sat_v(xs);
                n_ovf = r_ovf | sv[VB];
                if (r_step_crs) begin
                    // coarse step done, start a new increment group
                    n_crs      = SW'($signed(sv[VB-1:0]));
                    n_inc      = '0;
                    n_pos      = '0;
                    n_step_crs = 1'b0;
                    n_state    = r_last ? S_PAY : S_IDLE;
                end else begin
                    n_fine = SW'($signed(sv[VB-1:0]));
                    if (r_coupled) begin
                        n_state = S_INC;
                    end else begin
                        n_state = r_last ? S_PAY : S_IDLE;
                    end
                end
            end
            S_INC: begin
                // accumulate fine increments; a full group or path end steps the coarse path
                xs    = XW'(r_inc) + XW'(r_dw);
                sv    = sat_v(xs);
                n_inc = $signed(sv[VB-1:0]);
                n_ovf = r_ovf | sv[VB];
                if ((r_pos == POS_END) || r_last) begin
                    n_step_crs = 1'b1;
                    n_state    = S_VD_ISS;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PAY: begin
                // call payoffs, clamped then floored at zero
                xs    = XW'(r_fine) - XW'({1'b0, r_strike});
                xc    = XW'(r_crs) - XW'({1'b0, r_strike});
                sv    = sat_v(xs);
                sc    = sat_v(xc);
                n_pf  = sv[VB-1] ? '0 : $signed(sv[VB-1:0]);
                n_pc  = sc[VB-1] ? '0 : $signed(sc[VB-1:0]);
                // coarse payoff only counts in coupled mode
                n_ovf = r_ovf | sv[VB] | (r_coupled & sc[VB]);
                n_state = S_DIFF;
            end
            S_DIFF: begin
                xs = XW'(r_pf) - (r_coupled ? XW'(r_pc) : '0);
                if (xs > OMAX_X) begin
                    n_val = OMAX_X[gep_pkg::PATH_W-1:0];
                    n_ovf = 1'b1;
                end else if (xs < OMIN_X) begin
                    n_val = OMIN_X[gep_pkg::PATH_W-1:0];
                    n_ovf = 1'b1;
                end else begin
                    n_val = xs[gep_pkg::PATH_W-1:0];
                end
                n_state = S_TOT;
            end
            S_TOT: begin
                // wait for the output slot, then fold into the running total
                if (out_free) begin
                    ts = TW'(r_total) + TW'(r_val);
                    if (ts > TMAX) begin
                        n_total   = TMAX[gep_pkg::TOTAL_W-1:0];
                        n_out_sat = 1'b1;
                    end else if (ts < TMIN) begin
                        n_total   = TMIN[gep_pkg::TOTAL_W-1:0];
                        n_out_sat = 1'b1;
                    end else begin
                        n_total   = ts[gep_pkg::TOTAL_W-1:0];
                        n_out_sat = r_ovf;
                    end
                    n_count     = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;
                    n_out_valid = 1'b1;
                    n_out_val   = r_val;
                    n_out_total = n_total;
                    n_out_count = n_count;
                    // fresh path
                    n_fine      = ONE_S;
                    n_crs       = ONE_S;
                    n_inc       = '0;
                    n_pos       = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step_crs  <= 1'b0;
            r_fine      <= ONE_S;
            r_crs       <= ONE_S;
            r_inc       <= '0;
            r_pos       <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step_crs  <= n_step_crs;
            r_fine      <= n_fine;
            r_crs       <= n_crs;
            r_inc       <= n_inc;
            r_pos       <= n_pos;
            r_total     <= n_total;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_smp       <= n_smp;
        r_last      <= n_last;
        r_dw        <= n_dw;
        r_g         <= n_g;
        r_pf        <= n_pf;
        r_pc        <= n_pc;
        r_val       <= n_val;
        r_out_val   <= n_out_val;
        r_out_total <= n_out_total;
        r_out_count <= n_out_count;
        r_out_sat   <= n_out_sat;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_count, r_out_total, r_out_val};
    assign m_axis_tuser  = r_out_sat;

`ifndef NO_ASSERTIONS
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_TOT))
        else $error("result appeared without a finished path");

    a_total_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_TOT) && r_out_valid && !m_axis_tready) |=> (r_state == S_TOT))
        else $error("path finished over a pending result");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_count != '0))
        else $error("result carries a zero path count");
`endif

endmodule
